@@ rtl/core/ry420_pkg.sv @@
// Shared types, constants and arithmetic helpers for the RGB to YUV 4:2:0 converter.
// No dependencies; imported by every module of the block.
package ry420_pkg;

    localparam int CFG_W = 10;

    localparam logic CFG_PAIR_COLUMNS = 1'b0;
    localparam logic CFG_ROW_PAIRS    = 1'b1;

    localparam logic [CFG_W-1:0] PAIR_COLUMNS_RST = 10'd427;
    localparam logic [CFG_W-1:0] ROW_PAIRS_RST    = 10'd240;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = 2;
    localparam int QUEUE_LEVEL_W = 3;

    localparam logic [7:0] Y_K_R = 8'd66;
    localparam logic [7:0] Y_K_G = 8'd129;
    localparam logic [7:0] Y_K_B = 8'd25;

    localparam logic signed [8:0] U_K_R = -9'sd38;
    localparam logic signed [8:0] U_K_G = -9'sd74;
    localparam logic signed [8:0] U_K_B = 9'sd112;
    localparam logic signed [8:0] V_K_R = 9'sd112;
    localparam logic signed [8:0] V_K_G = -9'sd94;
    localparam logic signed [8:0] V_K_B = -9'sd18;

    localparam logic [7:0] LUMA_MIN   = 8'd16;
    localparam logic [7:0] LUMA_MAX   = 8'd235;
    localparam logic [7:0] CHROMA_MIN = 8'd16;
    localparam logic [7:0] CHROMA_MAX = 8'd240;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] chroma_blue_diff;
        logic [7:0] chroma_red_diff;
        logic       frame_end;
    } t_result;

    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } t_rgb_sum;

    typedef struct packed {
        t_pixel   pixel;
        t_rgb_sum pair_sum;
        t_rgb_sum line_sum;
        logic     chroma_valid;
        logic     frame_end;
    } t_queue_item;

    typedef struct packed {
        logic [QUEUE_LEVEL_W-1:0] level;
        logic                     empty;
    } t_queue_status;

    function automatic logic [7:0] f_luma(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        logic [16:0] s;
        logic [8:0]  y;
        s = 17'(Y_K_R) * 17'(r) + 17'(Y_K_G) * 17'(g) + 17'(Y_K_B) * 17'(b) + 17'(128);
        y = {1'b0, s[15:8]} + 9'(LUMA_MIN);
        if (y < 9'(LUMA_MIN)) begin
            return LUMA_MIN;
        end else if (y > 9'(LUMA_MAX)) begin
            return LUMA_MAX;
        end
        return y[7:0];
    endfunction

    // Offset of (128 << 8) + 128 keeps the sum positive, so the shift is plain.
    function automatic logic [7:0] f_chroma(input logic signed [8:0] kr,
                                            input logic signed [8:0] kg,
                                            input logic signed [8:0] kb,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic signed [18:0] s;
        logic [10:0]        c;
        s = 19'(kr) * 19'($signed({1'b0, r})) + 19'(kg) * 19'($signed({1'b0, g}))
          + 19'(kb) * 19'($signed({1'b0, b})) + 19'(32896);
        c = s[18:8];
        if (c < 11'(CHROMA_MIN)) begin
            return CHROMA_MIN;
        end else if (c > 11'(CHROMA_MAX)) begin
            return CHROMA_MAX;
        end
        return c[7:0];
    endfunction

endpackage

@@ rtl/core/ry420_front.sv @@
// Front end: geometry registers, raster position, left pixel hold and pair-sum line buffer.
// Classifies each accepted pixel and pushes it into the queue. Depends on ry420_pkg.
module ry420_front #(
    parameter int MAX_PAIR_COLUMNS = 512,
    parameter int MAX_ROW_PAIRS    = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  ry420_pkg::t_pixel                 i_pixel,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [ry420_pkg::CFG_W-1:0]       i_cfg_data,
    input  ry420_pkg::t_queue_status          i_status,
    output logic                              o_push,
    output ry420_pkg::t_queue_item            o_item
);
    import ry420_pkg::*;

    localparam int CW  = $clog2(2 * MAX_PAIR_COLUMNS);
    localparam int RW  = $clog2(2 * MAX_ROW_PAIRS);
    localparam int PW  = (MAX_PAIR_COLUMNS > 1) ? $clog2(MAX_PAIR_COLUMNS) : 1;
    localparam int CXW = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;
    localparam int RXW = (RW + 1 > CFG_W + 1) ? RW + 1 : CFG_W + 1;
    localparam int LW1 = QUEUE_LEVEL_W + 1;

    logic [CFG_W-1:0] r_pair_columns;
    logic [CFG_W-1:0] r_row_pairs;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    t_pixel           r_hold;
    logic             r_f1_valid;
    t_pixel           r_f1_pixel;
    t_rgb_sum         r_f1_sum;
    logic             r_f1_chroma;
    logic             r_f1_frame_end;
    t_rgb_sum         r_rd_data;
    t_rgb_sum         r_line [MAX_PAIR_COLUMNS];

    logic [CXW-1:0]   w_cols;
    logic [CXW-1:0]   w_last_col;
    logic [RXW-1:0]   w_rows;
    logic [RXW-1:0]   w_last_row;
    logic             w_line_end;
    logic             w_frame_end;
    logic [PW-1:0]    w_pair;
    t_rgb_sum         w_sum;
    logic             w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall = !i_rst_n
        || (LW1'(i_status.level) + LW1'(r_f1_valid) >= LW1'(QUEUE_DEPTH));
    assign w_accept = i_valid && !o_stall;
    assign w_pair = PW'(r_col >> 1);

    always_comb begin
        w_cols = CXW'(r_pair_columns);
        if (r_pair_columns == '0) begin
            w_cols = CXW'(1);
        end else if (w_cols > CXW'(MAX_PAIR_COLUMNS)) begin
            w_cols = CXW'(MAX_PAIR_COLUMNS);
        end
        w_rows = RXW'(r_row_pairs);
        if (r_row_pairs == '0) begin
            w_rows = RXW'(1);
        end else if (w_rows > RXW'(MAX_ROW_PAIRS)) begin
            w_rows = RXW'(MAX_ROW_PAIRS);
        end
        w_last_col  = (w_cols << 1) - CXW'(1);
        w_last_row  = (w_rows << 1) - RXW'(1);
        w_line_end  = CXW'(r_col) >= w_last_col;
        w_frame_end = w_line_end && (RXW'(r_row) >= w_last_row);
        w_sum.red   = 9'(r_hold.pixel_red) + 9'(i_pixel.pixel_red);
        w_sum.green = 9'(r_hold.pixel_green) + 9'(i_pixel.pixel_green);
        w_sum.blue  = 9'(r_hold.pixel_blue) + 9'(i_pixel.pixel_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_columns <= PAIR_COLUMNS_RST;
            r_row_pairs    <= ROW_PAIRS_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_hold         <= '0;
            r_f1_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PAIR_COLUMNS: r_pair_columns <= i_cfg_data;
                    CFG_ROW_PAIRS:    r_row_pairs    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_f1_valid <= w_accept;
            if (w_accept) begin
                if (!r_col[0]) begin
                    r_hold <= i_pixel;
                end
                if (w_line_end) begin
                    r_col <= '0;
                    r_row <= w_frame_end ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1_pixel     <= i_pixel;
            r_f1_sum       <= w_sum;
            r_f1_chroma    <= r_col[0] && r_row[0];
            r_f1_frame_end <= w_frame_end;
        end
    end

    // Line buffer: even rows store pair sums, odd rows read them back.
    always_ff @(posedge i_clk) begin
        if (w_accept && r_col[0]) begin
            if (!r_row[0]) begin
                r_line[w_pair] <= w_sum;
            end else begin
                r_rd_data <= r_line[w_pair];
            end
        end
    end

    assign o_push              = r_f1_valid;
    assign o_item.pixel        = r_f1_pixel;
    assign o_item.pair_sum     = r_f1_sum;
    assign o_item.line_sum     = r_rd_data;
    assign o_item.chroma_valid = r_f1_chroma;
    assign o_item.frame_end    = r_f1_frame_end;

endmodule

@@ rtl/core/ry420_queue.sv @@
// Small FIFO between the front end and the back end.
// Holds classified pixel transactions; depends on ry420_pkg.
module ry420_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  ry420_pkg::t_queue_item    i_item,
    input  logic                      i_pop,
    output ry420_pkg::t_queue_item    o_head,
    output ry420_pkg::t_queue_status  o_status
);
    import ry420_pkg::*;

    t_queue_item              r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   r_wr_ptr;
    logic [QUEUE_PTR_W-1:0]   r_rd_ptr;
    logic [QUEUE_LEVEL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + QUEUE_LEVEL_W'(1);
                2'b01:   r_level <= r_level - QUEUE_LEVEL_W'(1);
                default: r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.level = r_level;
    assign o_status.empty = (r_level == '0);

endmodule

@@ rtl/core/ry420_back.sv @@
// Two-stage back end: luma and 2x2 averaging, then chroma math into the output register.
// Pops transactions from the queue; depends on ry420_pkg.
module ry420_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ry420_pkg::t_queue_item    i_head,
    input  ry420_pkg::t_queue_status  i_status,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output ry420_pkg::t_result        o_result
);
    import ry420_pkg::*;

    logic       r_b1_valid;
    logic [7:0] r_b1_luma;
    logic [7:0] r_b1_avg_r;
    logic [7:0] r_b1_avg_g;
    logic [7:0] r_b1_avg_b;
    logic       r_b1_chroma;
    logic       r_b1_frame_end;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_advance;
    logic [9:0] w_tot_r;
    logic [9:0] w_tot_g;
    logic [9:0] w_tot_b;

    assign w_advance = !r_out_valid || !i_stall;
    assign o_pop     = w_advance && !i_status.empty;

    assign w_tot_r = 10'(i_head.pair_sum.red) + 10'(i_head.line_sum.red);
    assign w_tot_g = 10'(i_head.pair_sum.green) + 10'(i_head.line_sum.green);
    assign w_tot_b = 10'(i_head.pair_sum.blue) + 10'(i_head.line_sum.blue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_b1_valid  <= o_pop;
            r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_b1_luma      <= f_luma(i_head.pixel.pixel_red, i_head.pixel.pixel_green,
                                     i_head.pixel.pixel_blue);
            r_b1_avg_r     <= w_tot_r[9:2];
            r_b1_avg_g     <= w_tot_g[9:2];
            r_b1_avg_b     <= w_tot_b[9:2];
            r_b1_chroma    <= i_head.chroma_valid;
            r_b1_frame_end <= i_head.frame_end;

            r_out.luma         <= r_b1_luma;
            r_out.chroma_valid <= r_b1_chroma;
            r_out.frame_end    <= r_b1_frame_end;
            if (r_b1_chroma) begin
                r_out.chroma_blue_diff <= f_chroma(U_K_R, U_K_G, U_K_B,
                                                   r_b1_avg_r, r_b1_avg_g, r_b1_avg_b);
                r_out.chroma_red_diff  <= f_chroma(V_K_R, V_K_G, V_K_B,
                                                   r_b1_avg_r, r_b1_avg_g, r_b1_avg_b);
            end else begin
                r_out.chroma_blue_diff <= '0;
                r_out.chroma_red_diff  <= '0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

@@ rtl/core/rgb_to_yuv420_converter.sv @@
// Top level of the RGB to YUV 4:2:0 (BT.601 limited range) converter.
// Instantiates ry420_front, ry420_queue and ry420_back; depends on ry420_pkg.
//
// Usage:
//   Pixel channel (i_valid / o_stall / i_pixel): one RGB pixel per transaction in raster
//   order over a frame of 2*pair_columns by 2*row_pairs pixels.
//   Result channel (o_valid / i_stall / o_result): one transaction per pixel with its
//   luma; every odd-row, odd-column pixel also carries U and V of its 2x2 block, and the
//   last pixel of a frame has frame_end set.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 pair_columns, index 1 row_pairs;
//   always ready; to be written only while the block is idle, which it does not enforce.
// An accepted pixel passes the front register, the queue, the back-end first stage and the output register.
// Throughput: 1 pixel per clock while i_stall is low. Front end, line buffer (one write
// or one read per pixel pair) and two-stage back end all take one transaction per cycle.
// Reset: geometry returns to 427 x 240 pairs, position to the top left; the line buffer
// is not cleared and needs no clearing pass.
// When the receiver stalls, the output and back end hold, the 4-entry queue fills, and
// o_stall rises once queue plus front stage would overflow.
module rgb_to_yuv420_converter #(
    parameter int MAX_PAIR_COLUMNS = 512,
    parameter int MAX_ROW_PAIRS    = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  ry420_pkg::t_pixel            i_pixel,
    output logic                         o_valid,
    input  logic                         i_stall,
    output ry420_pkg::t_result           o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [ry420_pkg::CFG_W-1:0]  i_cfg_data
);
    import ry420_pkg::*;

    logic          w_push;
    logic          w_pop;
    t_queue_item   w_item;
    t_queue_item   w_head;
    t_queue_status w_status;

    ry420_front #(
        .MAX_PAIR_COLUMNS (MAX_PAIR_COLUMNS),
        .MAX_ROW_PAIRS    (MAX_ROW_PAIRS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (w_status),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    ry420_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    ry420_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_status.level != QUEUE_LEVEL_W'(QUEUE_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_status.empty)
        else $error("queue pop while empty");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.chroma_valid) |->
        (o_result.chroma_blue_diff == '0 && o_result.chroma_red_diff == '0))
        else $error("chroma not zero without chroma_valid");

    a_chroma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.chroma_valid) |->
        (o_result.chroma_blue_diff >= CHROMA_MIN && o_result.chroma_blue_diff <= CHROMA_MAX
         && o_result.chroma_red_diff >= CHROMA_MIN && o_result.chroma_red_diff <= CHROMA_MAX))
        else $error("chroma out of range");

endmodule
